@@ sv/byte_ring_packetizer_with_flush_defines.svh @@
// Assertion macros shared by the byte ring packetizer RTL.
`ifndef BYTE_RING_PACKETIZER_WITH_FLUSH_DEFINES_SVH
`define BYTE_RING_PACKETIZER_WITH_FLUSH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BRP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brp assertion failed");

`endif

@@ sv/brp_pkg.sv @@
// Shared constants, types and helpers for the byte ring packetizer.
`timescale 1ns / 1ps
package brp_pkg;

  localparam int RING_DEPTH    = 256;
  localparam int FRAME_PAYLOAD = 63;
  localparam int PTR_W         = $clog2(RING_DEPTH);
  localparam int CNT_W         = $clog2(FRAME_PAYLOAD + 1);
  localparam int BYTE_W        = 8;
  localparam int TICK_W        = 8;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd5;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [TICK_W-1:0] tick_t;

  localparam ptr_t PTR_LAST    = ptr_t'(RING_DEPTH - 1);
  localparam ptr_t PAYLOAD_PTR = ptr_t'(FRAME_PAYLOAD);
  localparam cnt_t PAYLOAD_CNT = cnt_t'(FRAME_PAYLOAD);

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_frame;
    logic emit_ovf;
  } brp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic push_full;
    logic tick_frame;
    logic out_free;
    logic last_beat;
  } brp_sts_t;

  function automatic ptr_t ring_next(input ptr_t p);
    return (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
  endfunction

endpackage

@@ sv/brp_ctrl.sv @@
// Sequencing state machine for the byte ring packetizer.
`timescale 1ns / 1ps
module brp_ctrl import brp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  brp_sts_t sts,
  output brp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FRAME = 2'd1;
  localparam logic [1:0] S_OVF   = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          if (sts.is_tick && sts.tick_frame) begin
            state_nxt = S_FRAME;
          end else if (!sts.is_tick && sts.push_full) begin
            state_nxt = S_OVF;
          end
        end
      end
      S_FRAME: begin
        // one beat per free output slot, back to idle after the last
        cmd.emit_frame = sts.out_free;
        if (sts.out_free && sts.last_beat) begin
          state_nxt = S_IDLE;
        end
      end
      S_OVF: begin
        cmd.emit_ovf = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/brp_datapath.sv @@
// Ring memory, pointers, idle counter and output register of the packetizer.
`timescale 1ns / 1ps
module brp_datapath import brp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_func,
  input  byte_t    in_data_byte,
  input  logic     cfg_wr_en,
  input  tick_t    cfg_wr_data,
  input  brp_cmd_t cmd,
  output brp_sts_t sts,
  output logic     out_valid,
  input  logic     out_stall,
  output byte_t    out_frame_byte,
  output logic     out_frame_last,
  output logic     out_overflow
);

  localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(RING_DEPTH);

  byte_t mem [RING_DEPTH];

  ptr_t  rd_ptr_r, rd_ptr_nxt;
  ptr_t  wr_ptr_r, wr_ptr_nxt;
  tick_t idle_r, idle_nxt;
  tick_t timeout_r;
  cnt_t  take_r, take_nxt;
  cnt_t  beat_r, beat_nxt;
  byte_t rd_data_r;
  byte_t out_byte_r, out_byte_nxt;
  logic  out_last_r, out_last_nxt;
  logic  out_ovf_r, out_ovf_nxt;
  logic  out_valid_r, out_valid_nxt;

  logic [PTR_W:0] diff;
  ptr_t  count;
  tick_t idle_inc;
  logic  full, push_ok, tick_acc, big, timed_out, beat_payload;

  assign full     = (ring_next(wr_ptr_r) == rd_ptr_r);
  assign push_ok  = cmd.accept && (in_func == FUNC_PUSH) && !full;
  assign tick_acc = cmd.accept && (in_func == FUNC_TICK);

  always_comb begin
    diff = {1'b0, wr_ptr_r} - {1'b0, rd_ptr_r};
    if (wr_ptr_r < rd_ptr_r) begin
      diff = diff + DEPTH_EXT;
    end
    count = diff[PTR_W-1:0];
  end

  assign idle_inc     = tick_t'(idle_r + 1'b1);
  assign big          = (count >= PAYLOAD_PTR);
  assign timed_out    = (count != '0) && !big && (idle_inc == timeout_r);
  assign beat_payload = (beat_r != '0) && (beat_r <= take_r);

  assign sts.is_tick    = (in_func == FUNC_TICK);
  assign sts.push_full  = full;
  assign sts.tick_frame = big || timed_out;
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.last_beat  = (beat_r == PAYLOAD_CNT);

  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = push_ok ? ring_next(wr_ptr_r) : wr_ptr_r;
    idle_nxt      = idle_r;
    take_nxt      = take_r;
    beat_nxt      = beat_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (tick_acc && (count != '0)) begin
      // a full frame or a timeout restarts the idle count
      idle_nxt = (big || timed_out) ? '0 : idle_inc;
      take_nxt = big ? PAYLOAD_CNT : count[CNT_W-1:0];
      beat_nxt = '0;
    end

    if (cmd.emit_frame) begin
      out_valid_nxt = 1'b1;
      out_ovf_nxt   = 1'b0;
      out_last_nxt  = (beat_r == PAYLOAD_CNT);
      beat_nxt      = cnt_t'(beat_r + 1'b1);
      if (beat_r == '0) begin
        out_byte_nxt = {{(BYTE_W - CNT_W){1'b0}}, take_r};
      end else if (beat_payload) begin
        out_byte_nxt = rd_data_r;
        rd_ptr_nxt   = ring_next(rd_ptr_r);
      end else begin
        out_byte_nxt = '0;
      end
    end else if (cmd.emit_ovf) begin
      out_valid_nxt = 1'b1;
      out_ovf_nxt   = 1'b1;
      out_last_nxt  = 1'b0;
      out_byte_nxt  = '0;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= in_data_byte;
    end
  end

  // Read port follows the next read pointer so rd_data_r holds the byte at the read pointer
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      idle_r      <= '0;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    take_r     <= take_nxt;
    beat_r     <= beat_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_last = out_last_r;
  assign out_overflow   = out_ovf_r;

endmodule

@@ sv/byte_ring_packetizer_with_flush.sv @@
// Top level of the byte ring packetizer with timeout flush.
//
// Input channel (in_valid / in_stall, in_func, in_data_byte): in_func low
// pushes in_data_byte into a 256-entry ring holding up to 255 bytes; in_func
// high is a send tick. Pushes run one per cycle while in_stall is low.
// A push to a full ring is dropped and reported by a single output beat with
// out_overflow set; the input stalls until that beat is in the output register.
// A tick with 63 or more bytes waiting sends a 64-beat frame: count byte 63,
// then 63 ring bytes. A tick with a partial backlog bumps the idle counter;
// when it hits flush_timeout the waiting bytes go out as a zero-padded frame.
// A tick on an empty ring does nothing.
// Output channel (out_valid / out_stall): one registered beat per cycle while
// out_stall is low, payload beats from the ring read port; an accepted frame
// tick is registered into take_r and the S_FRAME state before its count beat
// is loaded, and the input stalls until the frame's last beat is loaded.
// out_stall holds the output register and pauses the frame sequencer.
// cfg_wr_en / cfg_wr_data write flush_timeout, which resets to 5.
// Reset (rst_n low, synchronous) empties the ring and clears the idle counter;
// ring contents are not cleared.
`timescale 1ns / 1ps
`include "byte_ring_packetizer_with_flush_defines.svh"
module byte_ring_packetizer_with_flush import brp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  in_func,
  input  byte_t in_data_byte,
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_frame_byte,
  output logic  out_frame_last,
  output logic  out_overflow,
  input  logic  cfg_wr_en,
  input  tick_t cfg_wr_data
);

  brp_cmd_t cmd;
  brp_sts_t sts;

  brp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  brp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_data_byte   (in_data_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last),
    .out_overflow   (out_overflow)
  );

  `BRP_ASSERT_SAME(a_ovf_not_last, out_valid && out_overflow, !out_frame_last)
  `BRP_ASSERT_NEXT(a_frame_end_idle, cmd.emit_frame && sts.last_beat, !in_stall)
  `BRP_ASSERT_NEXT(a_full_push_holds, in_valid && !in_stall && !in_func && sts.push_full, in_stall)

endmodule

@@ sim/tb_byte_ring_packetizer_with_flush.sv @@
// Self-checking testbench for the byte ring packetizer with timeout flush.
`timescale 1ns / 1ps
module tb_byte_ring_packetizer_with_flush;
  import brp_pkg::*;

  localparam int ITEM_TARGET    = 360;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_PRINTED    = 50;

  typedef struct packed {
    byte_t frame_byte;
    logic  frame_last;
    logic  overflow;
  } beat_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  in_func = FUNC_PUSH;
  byte_t in_data_byte = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t out_frame_byte;
  logic  out_frame_last;
  logic  out_overflow;
  logic  cfg_wr_en = 1'b0;
  tick_t cfg_wr_data = '0;

  // Shadow copy of the block state
  byte_t shadow_ring [RING_DEPTH];
  ptr_t  shadow_rd = '0;
  ptr_t  shadow_wr = '0;
  tick_t shadow_idle = '0;
  tick_t shadow_timeout = TIMEOUT_RESET;

  beat_t pending_beats[$];
  int    mismatch_count = 0;
  int    items_accepted = 0;
  int    quiet_cycles = 0;
  int    hold_left = 0;
  bit    idle_en = 1'b1;

  byte_ring_packetizer_with_flush dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last),
    .out_overflow   (out_overflow),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Work out the output beats, frame or overflow, that one accepted input beat causes.
  task automatic predict_frame_beats(input logic func, input byte_t data);
    int unsigned backlog;
    int unsigned take;
    byte_t b;
    backlog = int'(ptr_t'(shadow_wr - shadow_rd));
    take = 0;
    if (func == FUNC_PUSH) begin
      if (ptr_t'(shadow_wr + 1) == shadow_rd) begin
        pending_beats.push_back('{frame_byte: 8'h00, frame_last: 1'b0, overflow: 1'b1});
      end else begin
        shadow_ring[shadow_wr] = data;
        shadow_wr = ptr_t'(shadow_wr + 1);
      end
    end else if (backlog != 0) begin
      if (backlog >= FRAME_PAYLOAD) begin
        shadow_idle = '0;
        take = FRAME_PAYLOAD;
      end else begin
        shadow_idle = tick_t'(shadow_idle + 1);
        if (shadow_idle == shadow_timeout) begin
          shadow_idle = '0;
          take = backlog;
        end
      end
    end
    if (take != 0) begin
      pending_beats.push_back('{frame_byte: byte_t'(take), frame_last: 1'b0, overflow: 1'b0});
      for (int i = 0; i < FRAME_PAYLOAD; i++) begin
        b = '0;
        if (i < take) begin
          b = shadow_ring[shadow_rd];
          shadow_rd = ptr_t'(shadow_rd + 1);
        end
        pending_beats.push_back('{frame_byte: b, frame_last: (i == FRAME_PAYLOAD - 1),
                                  overflow: 1'b0});
      end
    end
  endtask

  // Offer one beat and hold it until the block takes it.
  task automatic send_item(input logic func, input byte_t data);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame_beats(func, data);
    items_accepted++;
  endtask

  task automatic push_bytes(input int n);
    repeat (n) send_item(FUNC_PUSH, byte_t'($urandom));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(FUNC_TICK, byte_t'($urandom));
  endtask

  // Stop offering and wait for every frame beat, plus the pipeline tail.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeout(input tick_t value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_timeout = value;
  endtask

  // Default timeout, empty-ring tick, short flush, timeout of one.
  task automatic test_directed();
    send_item(FUNC_TICK, 8'hFF);
    send_item(FUNC_PUSH, 8'h00);
    send_item(FUNC_PUSH, 8'hFF);
    send_item(FUNC_PUSH, 8'h5A);
    send_ticks(5);
    set_timeout(8'd1);
    send_item(FUNC_PUSH, 8'hA5);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_TICK, 8'h3C);
    settle();
  endtask

  // Retarget a running idle count from the largest timeout, then the frame threshold.
  task automatic test_full_frames();
    set_timeout(8'hFF);
    push_bytes(2);
    send_ticks(3);
    set_timeout(8'd4);
    send_ticks(1);
    // one short of a frame counts as backlog, one more makes a full frame
    push_bytes(FRAME_PAYLOAD - 1);
    send_ticks(1);
    push_bytes(1);
    send_ticks(1);
    settle();
  endtask

  // Fill the ring while the receiver holds off, then push past full.
  task automatic test_overflow_pressure();
    set_timeout(8'd7);
    idle_en = 1'b0;
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    @(posedge clk);
    while (ptr_t'(shadow_wr - shadow_rd) != PTR_LAST) push_bytes(1);
    push_bytes(3);
    send_ticks(4);
    push_bytes(2);
    send_ticks(7);
    settle();
    idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int since_cfg;
    int pick;
    since_cfg = 0;
    while (items_accepted < ITEM_TARGET) begin
      if (since_cfg >= 60) begin
        set_timeout(tick_t'($urandom_range(1, 6)));
        since_cfg = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_bytes($urandom_range(1, 70));
        send_ticks(1);
      end else if (pick < 85) begin
        send_ticks($urandom_range(1, 3));
      end else begin
        push_bytes($urandom_range(1, 5));
      end
      since_cfg++;
    end
    settle();
  endtask

  // Receiver: random stall, forced hold-off, and the beat check.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%02h last=%0b ovf=%0b",
                                  out_frame_byte, out_frame_last, out_overflow));
      end else begin
        beat_t exp_beat;
        exp_beat = pending_beats.pop_front();
        if (out_frame_byte !== exp_beat.frame_byte)
          report_mismatch($sformatf("frame_byte %02h, want %02h",
                                    out_frame_byte, exp_beat.frame_byte));
        if (out_frame_last !== exp_beat.frame_last)
          report_mismatch($sformatf("frame_last %0b, want %0b",
                                    out_frame_last, exp_beat.frame_last));
        if (out_overflow !== exp_beat.overflow)
          report_mismatch($sformatf("overflow %0b, want %0b",
                                    out_overflow, exp_beat.overflow));
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= idle_en && ($urandom_range(0, 2) == 0);
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_frames();
    test_overflow_pressure();
    test_random_traffic();
    settle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
